// ----- hdl/aled_pkg.sv -----
// -----------------------------------------------------------------------------
// Addressable LED bit encoder package
// Shared widths, codes and the color order table.
// -----------------------------------------------------------------------------
package aled_pkg;

   localparam int CHAN_W   = 8;
   localparam int SCALE_W  = CHAN_W + 1;
   localparam int WORD_W   = 32;
   localparam int SHIFT_W  = 5;
   localparam int BITS_W   = 3 * CHAN_W;
   localparam int CNT_W    = 5;
   localparam int HIGH_W   = 3;
   localparam int LOW_W    = 10;
   localparam int ORDER_W  = 3;
   localparam int RESET_SLOTS_DEF = 1000;

   localparam logic [HIGH_W-1:0] HIGH_ZERO = HIGH_W'(1);
   localparam logic [HIGH_W-1:0] HIGH_ONE  = HIGH_W'(4);
   localparam logic [HIGH_W-1:0] HIGH_RST  = HIGH_W'(0);
   localparam logic [LOW_W-1:0]  LOW_ZERO  = LOW_W'(4);
   localparam logic [LOW_W-1:0]  LOW_ONE   = LOW_W'(1);

   localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(BITS_W - 1);

   typedef enum logic [1:0] {
      KIND_PIXEL = 2'd0,
      KIND_RAW   = 2'd1,
      KIND_LATCH = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      SYM_ZERO  = 2'd0,
      SYM_ONE   = 2'd1,
      SYM_RESET = 2'd2
   } symbol_type;

   typedef enum logic [0:0] {
      CSR_BRIGHTNESS  = 1'b0,
      CSR_COLOR_ORDER = 1'b1
   } csr_index_type;

   // Bits 23..16 red shift, 15..8 green shift, 7..0 blue shift.
   localparam logic [BITS_W-1:0] ORDER_TABLE [8] = '{
      24'h100800, 24'h100008, 24'h081000, 24'h080010,
      24'h001008, 24'h000810, 24'h100800, 24'h100800
   };

   typedef struct packed {
      logic              latch;
      logic [BITS_W-1:0] bits;
      logic              last;
   } hold_type;

endpackage

// ----- hdl/addressable_led_bit_encoder_top.sv -----
// -----------------------------------------------------------------------------
// Addressable LED bit encoder
// Turns pixel, raw and latch requests into one-wire LED line symbols.
// -----------------------------------------------------------------------------
// A pixel or raw request yields 24 symbols, one per cycle while rsp_tready is
// high; a latch request yields one symbol. The symbol shifter sets this rate,
// and a holding register in front of it takes the next request while the
// current one is sent.
module addressable_led_bit_encoder_top #(
   parameter int RESET_SLOTS = aled_pkg::RESET_SLOTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // pixel_word, red, green, blue
   input  logic [1:0]  req_tuser,   // kind
   input  logic        req_tlast,   // frame_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // high_slots, low_slots, item_end, zero fill
   output logic [1:0]  rsp_tuser,   // symbol
   output logic        rsp_tlast,   // frame_end
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [7:0]  csr_wdata
);
   import aled_pkg::*;

   logic [CHAN_W-1:0]  brightness_ff;
   logic [ORDER_W-1:0] color_order_ff;
   logic [BITS_W-1:0]  order;
   logic [SCALE_W-1:0] scale;
   logic [CHAN_W-1:0]  lane_red, lane_green, lane_blue;
   logic               hold_valid, hold_take;
   hold_type           hold;
   symbol_type         symbol;
   logic [HIGH_W-1:0]  high_slots;
   logic [LOW_W-1:0]   low_slots;
   logic               item_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         brightness_ff  <= 8'hff;
         color_order_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_BRIGHTNESS:  brightness_ff  <= csr_wdata;
            CSR_COLOR_ORDER: color_order_ff <= csr_wdata[ORDER_W-1:0];
            default: ;
         endcase
      end
   end

   assign order = ORDER_TABLE[color_order_ff];
   assign scale = SCALE_W'(brightness_ff) + SCALE_W'(1);

   aled_lane u_lane_red (
      .word  (req_tdata[WORD_W-1:0]),
      .shift (order[16 +: SHIFT_W]),
      .scale (scale),
      .level (lane_red)
   );

   aled_lane u_lane_green (
      .word  (req_tdata[WORD_W-1:0]),
      .shift (order[8 +: SHIFT_W]),
      .scale (scale),
      .level (lane_green)
   );

   aled_lane u_lane_blue (
      .word  (req_tdata[WORD_W-1:0]),
      .shift (order[0 +: SHIFT_W]),
      .scale (scale),
      .level (lane_blue)
   );

   aled_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .kind       (kind_type'(req_tuser)),
      .last       (req_tlast),
      .lane_red   (lane_red),
      .lane_green (lane_green),
      .lane_blue  (lane_blue),
      .raw_red    (req_tdata[39:32]),
      .raw_green  (req_tdata[47:40]),
      .raw_blue   (req_tdata[55:48]),
      .hold_valid (hold_valid),
      .hold_take  (hold_take),
      .hold       (hold)
   );

   aled_serializer #(
      .RESET_SLOTS (RESET_SLOTS)
   ) u_serializer (
      .clock      (clock),
      .reset      (reset),
      .hold_valid (hold_valid),
      .hold_take  (hold_take),
      .hold       (hold),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .symbol     (symbol),
      .high_slots (high_slots),
      .low_slots  (low_slots),
      .item_end   (item_end),
      .frame_end  (rsp_tlast)
   );

   assign rsp_tuser = symbol;
   assign rsp_tdata = {2'b00, item_end, low_slots, high_slots};

endmodule

// ----- hdl/aled_lane.sv -----
// -----------------------------------------------------------------------------
// Addressable LED channel lane
// Picks one color byte from the pixel word and scales it by brightness.
// -----------------------------------------------------------------------------
module aled_lane (
   input  logic [aled_pkg::WORD_W-1:0]  word,
   input  logic [aled_pkg::SHIFT_W-1:0] shift,
   input  logic [aled_pkg::SCALE_W-1:0] scale,
   output logic [aled_pkg::CHAN_W-1:0]  level
);
   import aled_pkg::*;

   logic [WORD_W-1:0]          shifted;
   logic [CHAN_W+SCALE_W-1:0]  product;

   always_comb begin
      shifted = word >> shift;
      product = (CHAN_W+SCALE_W)'(shifted[CHAN_W-1:0]) * (CHAN_W+SCALE_W)'(scale);
      level   = product[2*CHAN_W-1:CHAN_W];
   end

endmodule

// ----- hdl/aled_merge.sv -----
// -----------------------------------------------------------------------------
// Addressable LED merge stage
// Combines the lane results or the raw bytes into one registered bit word.
// -----------------------------------------------------------------------------
module aled_merge (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  aled_pkg::kind_type          kind,
   input  logic                        last,
   input  logic [aled_pkg::CHAN_W-1:0] lane_red,
   input  logic [aled_pkg::CHAN_W-1:0] lane_green,
   input  logic [aled_pkg::CHAN_W-1:0] lane_blue,
   input  logic [aled_pkg::CHAN_W-1:0] raw_red,
   input  logic [aled_pkg::CHAN_W-1:0] raw_green,
   input  logic [aled_pkg::CHAN_W-1:0] raw_blue,
   output logic                        hold_valid,
   input  logic                        hold_take,
   output aled_pkg::hold_type          hold
);
   import aled_pkg::*;

   logic     valid_ff, valid_in;
   hold_type hold_ff, hold_in;
   logic     load;

   assign in_ready   = !valid_ff || hold_take;
   assign hold_valid = valid_ff;
   assign hold       = hold_ff;
   assign load       = in_valid && in_ready && (kind != KIND_NONE);

   always_comb begin
      hold_in       = hold_ff;
      hold_in.latch = (kind == KIND_LATCH);
      hold_in.last  = last;
      if (kind == KIND_RAW) begin
         hold_in.bits = {raw_green, raw_red, raw_blue};
      end else begin
         hold_in.bits = {lane_green, lane_red, lane_blue};
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (hold_take) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         hold_ff <= hold_in;
      end
   end

endmodule

// ----- hdl/aled_serializer.sv -----
// -----------------------------------------------------------------------------
// Addressable LED serializer
// Shifts the bit word out as line symbols, most significant bit first.
// -----------------------------------------------------------------------------
module aled_serializer #(
   parameter int RESET_SLOTS = aled_pkg::RESET_SLOTS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        hold_valid,
   output logic                        hold_take,
   input  aled_pkg::hold_type          hold,
   output logic                        out_valid,
   input  logic                        out_ready,
   output aled_pkg::symbol_type        symbol,
   output logic [aled_pkg::HIGH_W-1:0] high_slots,
   output logic [aled_pkg::LOW_W-1:0]  low_slots,
   output logic                        item_end,
   output logic                        frame_end
);
   import aled_pkg::*;

   localparam logic [LOW_W-1:0] LOW_RST = LOW_W'(RESET_SLOTS);

   logic              valid_ff, valid_in;
   logic [BITS_W-1:0] bits_ff, bits_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              latch_ff, latch_in;
   logic              last_ff, last_in;
   logic              done;

   assign done      = out_valid && out_ready && item_end;
   assign hold_take = hold_valid && (!valid_ff || done);

   always_comb begin
      valid_in = valid_ff;
      bits_in  = bits_ff;
      cnt_in   = cnt_ff;
      latch_in = latch_ff;
      last_in  = last_ff;
      if (hold_take) begin
         valid_in = 1'b1;
         bits_in  = hold.bits;
         cnt_in   = '0;
         latch_in = hold.latch;
         last_in  = hold.last;
      end else if (done) begin
         valid_in = 1'b0;
      end else if (valid_ff && out_ready) begin
         bits_in = {bits_ff[BITS_W-2:0], 1'b0};
         cnt_in  = cnt_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bits_ff  <= bits_in;
      cnt_ff   <= cnt_in;
      latch_ff <= latch_in;
      last_ff  <= last_in;
   end

   always_comb begin
      out_valid = valid_ff;
      item_end  = latch_ff || (cnt_ff == LAST_BIT);
      frame_end = item_end && last_ff;
      if (latch_ff) begin
         symbol     = SYM_RESET;
         high_slots = HIGH_RST;
         low_slots  = LOW_RST;
      end else if (bits_ff[BITS_W-1]) begin
         symbol     = SYM_ONE;
         high_slots = HIGH_ONE;
         low_slots  = LOW_ONE;
      end else begin
         symbol     = SYM_ZERO;
         high_slots = HIGH_ZERO;
         low_slots  = LOW_ZERO;
      end
   end

endmodule

// ----- hdl/aled_checker.sv -----
// -----------------------------------------------------------------------------
// Addressable LED bit encoder checker
// Port-level checks on the symbol stream, bound to the top level.
// -----------------------------------------------------------------------------
module aled_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);
   import aled_pkg::*;

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("Symbol changed while stalled.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == SYM_RESET |-> rsp_tdata[13] && rsp_tdata[2:0] == HIGH_RST)
      else $error("Latch symbol is malformed.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[13])
      else $error("Frame end without request end.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != SYM_RESET |->
         (rsp_tdata[2:0] == HIGH_ONE && rsp_tdata[12:3] == LOW_ONE && rsp_tuser == SYM_ONE) ||
         (rsp_tdata[2:0] == HIGH_ZERO && rsp_tdata[12:3] == LOW_ZERO && rsp_tuser == SYM_ZERO))
      else $error("Data symbol timing does not match its value.");

endmodule

bind addressable_led_bit_encoder_top aled_checker u_aled_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
